// ===== hw/rtl/estm_pkg.sv =====
// shared types, constants and tables for the euler scale translate matrix block
`timescale 1ns / 1ps
package estm_pkg;

    localparam int CORDIC_STEPS  = 24;
    localparam int CORDIC_STAGES = CORDIC_STEPS + 1;
    localparam int MAT_STAGES    = 5;
    localparam int TOTAL_STAGES  = CORDIC_STAGES + MAT_STAGES;
    localparam int SCALE_STAGE   = CORDIC_STAGES + 2;

    localparam int CW = 34;   // cordic datapath width
    localparam int TW = 18;   // sine and cosine width, q16

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [TW-1:0] ONE_Q16     = 18'sd65536;
    localparam logic signed [TW-1:0] MONE_Q16    = -18'sd65536;

    typedef struct packed {
        logic        [15:0] angle_x;
        logic        [15:0] angle_y;
        logic        [15:0] angle_z;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic signed [15:0] scale_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_in;

    typedef struct packed {
        logic signed [23:0] m00;
        logic signed [23:0] m01;
        logic signed [23:0] m02;
        logic signed [23:0] m10;
        logic signed [23:0] m11;
        logic signed [23:0] m12;
        logic signed [23:0] m20;
        logic signed [23:0] m21;
        logic signed [23:0] m22;
        logic signed [31:0] t_x;
        logic signed [31:0] t_y;
        logic signed [31:0] t_z;
    } t_out;

    typedef struct packed {
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic signed [15:0] scale_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_pass;

    // atan(2^-i) in units of 2^32 per turn
    function automatic logic signed [CW-1:0] atan_turn(input int idx);
        logic signed [CW-1:0] v;
        begin
            case (idx)
                0:  v = 34'sd536870912;
                1:  v = 34'sd316933406;
                2:  v = 34'sd167458907;
                3:  v = 34'sd85004756;
                4:  v = 34'sd42667331;
                5:  v = 34'sd21354465;
                6:  v = 34'sd10679838;
                7:  v = 34'sd5340245;
                8:  v = 34'sd2670163;
                9:  v = 34'sd1335087;
                10: v = 34'sd667544;
                11: v = 34'sd333772;
                12: v = 34'sd166886;
                13: v = 34'sd83443;
                14: v = 34'sd41722;
                15: v = 34'sd20861;
                16: v = 34'sd10430;
                17: v = 34'sd5215;
                18: v = 34'sd2608;
                19: v = 34'sd1304;
                20: v = 34'sd652;
                21: v = 34'sd326;
                22: v = 34'sd163;
                23: v = 34'sd81;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== hw/rtl/euler_scale_translate_matrix_top.sv =====
// top level of the euler angle, scale and translation to transform matrix block
`timescale 1ns / 1ps
// usage:
//   input channel i_valid / o_stall / i_data carries one transform per
//   transaction: three binary angles, three q8.8 row scales, a q16.16 position
//   output channel o_valid / i_stall / o_data carries the nine scaled y-x-z
//   rotation entries in q8.16 and the position as the translation row
//   the pipeline has 30 stages: 24 cordic iterations, one round and quadrant
//   stage, then five product, sum, scale and round stages; the first stage
//   loads at the accepting edge, and o_valid is the valid bit of the last
//   stage, so the result can be taken once the transaction reaches it
//   throughput is one transaction per cycle while the receiver does not
//   stall, set by the fully pipelined cordic lanes and matrix stages
//   every stage carries its own valid bit, an empty stage always loads, so
//   bubbles close up while the receiver stalls; o_stall rises only when all
//   30 stages hold a transaction and the output is stalled
//   reset empties the pipeline; no transaction is lost or repeated on stall
module euler_scale_translate_matrix_top
    import estm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    // per stage valid bits and load enables
    logic [TOTAL_STAGES-1:0] r_vld;
    logic [TOTAL_STAGES:0]   en;

    always_comb begin
        en[TOTAL_STAGES] = !i_stall;
        for (int k = TOTAL_STAGES - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[TOTAL_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < TOTAL_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // scale and position ride alongside the datapath
    t_pass r_pass [0:TOTAL_STAGES-1];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < TOTAL_STAGES; k++) begin
            if (en[k]) begin
                if (k == 0) begin
                    r_pass[k] <= '{i_data.scale_x, i_data.scale_y, i_data.scale_z,
                                   i_data.pos_x, i_data.pos_y, i_data.pos_z};
                end else begin
                    r_pass[k] <= r_pass[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // three sine / cosine lanes
    logic signed [TW-1:0] sx, cx, sy, cy, sz, cz;

    estm_cordic u_cordic_x (
        .i_clk   (i_clk),
        .i_en    (en[CORDIC_STAGES-1:0]),
        .i_angle (i_data.angle_x),
        .o_sin   (sx),
        .o_cos   (cx)
    );

    estm_cordic u_cordic_y (
        .i_clk   (i_clk),
        .i_en    (en[CORDIC_STAGES-1:0]),
        .i_angle (i_data.angle_y),
        .o_sin   (sy),
        .o_cos   (cy)
    );

    estm_cordic u_cordic_z (
        .i_clk   (i_clk),
        .i_en    (en[CORDIC_STAGES-1:0]),
        .i_angle (i_data.angle_z),
        .o_sin   (sz),
        .o_cos   (cz)
    );

    // matrix entries, scale taken at the row scaling stage
    logic signed [23:0] m [0:8];

    estm_matrix u_matrix (
        .i_clk     (i_clk),
        .i_en      (en[TOTAL_STAGES-1:CORDIC_STAGES]),
        .i_sx      (sx),
        .i_cx      (cx),
        .i_sy      (sy),
        .i_cy      (cy),
        .i_sz      (sz),
        .i_cz      (cz),
        .i_scale_x (r_pass[SCALE_STAGE].scale_x),
        .i_scale_y (r_pass[SCALE_STAGE].scale_y),
        .i_scale_z (r_pass[SCALE_STAGE].scale_z),
        .o_m       (m)
    );

    always_comb begin
        o_data.m00 = m[0];
        o_data.m01 = m[1];
        o_data.m02 = m[2];
        o_data.m10 = m[3];
        o_data.m11 = m[4];
        o_data.m12 = m[5];
        o_data.m20 = m[6];
        o_data.m21 = m[7];
        o_data.m22 = m[8];
        o_data.t_x = r_pass[TOTAL_STAGES-1].pos_x;
        o_data.t_y = r_pass[TOTAL_STAGES-1].pos_y;
        o_data.t_z = r_pass[TOTAL_STAGES-1].pos_z;
    end

    // input stalls only with a full pipeline and a stalled output
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld && i_stall))
        else $error("input stalled with a free stage");

    // accepted transaction lands in the first stage
    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted transaction not captured");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled result changed");

endmodule

// ===== hw/rtl/estm_cordic.sv =====
// pipelined cordic sine and cosine lane, one iteration per stage
`timescale 1ns / 1ps
module estm_cordic
    import estm_pkg::*;
(
    input  logic                     i_clk,
    input  logic [CORDIC_STAGES-1:0] i_en,
    input  logic [15:0]              i_angle,
    output logic signed [TW-1:0]     o_sin,
    output logic signed [TW-1:0]     o_cos
);

    logic signed [CW-1:0] r_x [0:CORDIC_STEPS-1];
    logic signed [CW-1:0] r_y [0:CORDIC_STEPS-1];
    logic signed [CW-1:0] r_z [0:CORDIC_STEPS-1];
    logic [1:0]           r_q [0:CORDIC_STEPS-1];
    logic signed [TW-1:0] r_sin;
    logic signed [TW-1:0] r_cos;

    genvar g;
    generate
        for (g = 0; g < CORDIC_STEPS; g++) begin : g_step
            logic signed [CW-1:0] x_in, y_in, z_in;
            logic [1:0]           q_in;
            logic signed [CW-1:0] n_x, n_y, n_z;
            if (g == 0) begin : g_first
                assign x_in = CORDIC_GAIN;
                assign y_in = '0;
                assign z_in = CW'({2'b00, i_angle[13:0], 16'h0000});
                assign q_in = i_angle[15:14];
            end else begin : g_rest
                assign x_in = r_x[g-1];
                assign y_in = r_y[g-1];
                assign z_in = r_z[g-1];
                assign q_in = r_q[g-1];
            end
            always_comb begin
                if (!z_in[CW-1]) begin
                    n_x = x_in - (y_in >>> g);
                    n_y = y_in + (x_in >>> g);
                    n_z = z_in - atan_turn(g);
                end else begin
                    n_x = x_in + (y_in >>> g);
                    n_y = y_in - (x_in >>> g);
                    n_z = z_in + atan_turn(g);
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en[g]) begin
                    r_x[g] <= n_x;
                    r_y[g] <= n_y;
                    r_z[g] <= n_z;
                    r_q[g] <= q_in;
                end
            end
        end
    endgenerate

    // round to q16, clamp, then fold in the quadrant
    logic signed [CW-1:0] xr, yr;
    logic signed [TW-1:0] c_cl, s_cl, n_sin, n_cos;

    always_comb begin
        xr = (r_x[CORDIC_STEPS-1] + CW'(8192)) >>> 14;
        yr = (r_y[CORDIC_STEPS-1] + CW'(8192)) >>> 14;
        if (xr > CW'(ONE_Q16))       c_cl = ONE_Q16;
        else if (xr < CW'(MONE_Q16)) c_cl = MONE_Q16;
        else                         c_cl = TW'(xr);
        if (yr > CW'(ONE_Q16))       s_cl = ONE_Q16;
        else if (yr < CW'(MONE_Q16)) s_cl = MONE_Q16;
        else                         s_cl = TW'(yr);
        case (r_q[CORDIC_STEPS-1])
            2'd0: begin n_cos = c_cl;  n_sin = s_cl;  end
            2'd1: begin n_cos = -s_cl; n_sin = c_cl;  end
            2'd2: begin n_cos = -c_cl; n_sin = -s_cl; end
            default: begin n_cos = s_cl; n_sin = -c_cl; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[CORDIC_STEPS]) begin
            r_sin <= n_sin;
            r_cos <= n_cos;
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

// ===== hw/rtl/estm_matrix.sv =====
// rotation matrix products, row scaling, rounding and saturation stages
`timescale 1ns / 1ps
module estm_matrix
    import estm_pkg::*;
(
    input  logic                  i_clk,
    input  logic [MAT_STAGES-1:0] i_en,
    input  logic signed [TW-1:0]  i_sx,
    input  logic signed [TW-1:0]  i_cx,
    input  logic signed [TW-1:0]  i_sy,
    input  logic signed [TW-1:0]  i_cy,
    input  logic signed [TW-1:0]  i_sz,
    input  logic signed [TW-1:0]  i_cz,
    input  logic signed [15:0]    i_scale_x,
    input  logic signed [15:0]    i_scale_y,
    input  logic signed [15:0]    i_scale_z,
    output logic signed [23:0]    o_m [0:8]
);

    localparam int PW = 2 * TW;
    localparam int SW = 56;

    // stage 1: pairwise products
    logic signed [PW-1:0] r_cycz, r_sysz, r_cysx, r_czsy, r_cysz;
    logic signed [PW-1:0] r_cxsz, r_cxcz, r_cxsy, r_cxcy;
    logic signed [TW-1:0] r1_sx, r1_sz;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_cycz <= i_cy * i_cz;
            r_sysz <= i_sy * i_sz;
            r_cysx <= i_cy * i_sx;
            r_czsy <= i_cz * i_sy;
            r_cysz <= i_cy * i_sz;
            r_cxsz <= i_cx * i_sz;
            r_cxcz <= i_cx * i_cz;
            r_cxsy <= i_cx * i_sy;
            r_cxcy <= i_cx * i_cy;
            r1_sx  <= i_sx;
            r1_sz  <= i_sz;
        end
    end

    // stage 2: triple products, the rest shifted to q48
    logic signed [SW-1:0] r_a [0:8];
    logic signed [SW-1:0] r_b [0:3];

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_a[0] <= SW'(r_cycz) <<< 16;
            r_a[1] <= SW'(r_cxsz) <<< 16;
            r_a[2] <= SW'(r_czsy) <<< 16;
            r_a[3] <= SW'(r_cysz) <<< 16;
            r_a[4] <= SW'(r_cxcz) <<< 16;
            r_a[5] <= SW'(r_sysz) <<< 16;
            r_a[6] <= SW'(r_cxsy) <<< 16;
            r_a[7] <= -(SW'(r1_sx) <<< 32);
            r_a[8] <= SW'(r_cxcy) <<< 16;
            r_b[0] <= SW'(r_sysz * r1_sx);
            r_b[1] <= SW'(r_cysx * r1_sz);
            r_b[2] <= SW'(r_czsy * r1_sx);
            r_b[3] <= SW'(r_cycz * r1_sx);
        end
    end

    // stage 3: bracket sums rounded to q24
    logic signed [SW-1:0] term [0:8];
    logic signed [31:0]   r_t24 [0:8];

    always_comb begin
        term[0] = r_a[0] + r_b[0];
        term[1] = r_a[1];
        term[2] = r_b[1] - r_a[2];
        term[3] = r_b[2] - r_a[3];
        term[4] = r_a[4];
        term[5] = r_b[3] + r_a[5];
        term[6] = r_a[6];
        term[7] = r_a[7];
        term[8] = r_a[8];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            for (int k = 0; k < 9; k++) begin
                r_t24[k] <= 32'((term[k] + (SW'(1) <<< 23)) >>> 24);
            end
        end
    end

    // stage 4: row scaling
    logic signed [47:0] r_p [0:8];
    logic signed [15:0] row_scale [0:8];

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            if (k < 3)      row_scale[k] = i_scale_x;
            else if (k < 6) row_scale[k] = i_scale_y;
            else            row_scale[k] = i_scale_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            for (int k = 0; k < 9; k++) begin
                r_p[k] <= r_t24[k] * row_scale[k];
            end
        end
    end

    // stage 5: round to q16 and saturate
    logic signed [47:0] rq [0:8];
    logic signed [23:0] r_m [0:8];

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            rq[k] = (r_p[k] + 48'sd32768) >>> 16;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            for (int k = 0; k < 9; k++) begin
                if (rq[k] > 48'sd8388607)       r_m[k] <= 24'sh7fffff;
                else if (rq[k] < -48'sd8388608) r_m[k] <= 24'sh800000;
                else                            r_m[k] <= 24'(rq[k]);
            end
        end
    end

    assign o_m = r_m;

endmodule
